// ===== rtl/pfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, codes and memory write bundles for the page frame
// allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int NUM_PAGES  = 64;
    localparam int PAGE_SHIFT = 12;

    localparam int IDX_W  = $clog2(NUM_PAGES);
    localparam int LINK_W = IDX_W + 1;
    localparam int CNT_W  = $clog2(NUM_PAGES + 1);
    localparam int TAG_W  = 9;

    localparam logic [LINK_W-1:0] NULL_LINK    = LINK_W'(NUM_PAGES);
    localparam logic [7:0]        KERNEL_OWNER = 8'hFF;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_INIT   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OOM      = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_NOINIT   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic [1:0] CFG_BASE     = 2'd0;
    localparam logic [1:0] CFG_TOTAL    = 2'd1;
    localparam logic [1:0] CFG_RESERVED = 2'd2;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [TAG_W-1:0] data;
    } tag_wr_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } link_wr_t;

endpackage
`default_nettype wire

// ===== rtl/page_frame_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_allocator
// Free-list page frame manager with owner tags and link memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result is shown
// for one cycle with done high and cannot be held off. Lookup, error cases,
// a repeated init and a free of an empty pool finish straight from idle.
// Init writes each page in the pool (min(page_total, NUM_PAGES)) in turn,
// allocate pops pages off the free list one by one, and free scans each page
// in the pool, all through the single write port of the tag and link
// memories. Configuration is written through cfg_we / cfg_index / cfg_data;
// the user must write it only while busy is low, the block does not enforce it.
module page_frame_allocator
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  owner_id,
    input  wire logic [6:0]  req_pages,
    input  wire logic [31:0] address,
    output logic             done,
    output logic [2:0]       status,
    output logic [31:0]      page_address,
    output logic [5:0]       page_index,
    output logic [6:0]       pages_freed,
    output logic [6:0]       pages_in_use,
    output logic [6:0]       peak_pages,
    output logic [31:0]      freed_total
);
    import pfa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INIT = 4'b0010,
        S_POP  = 4'b0100,
        S_SCAN = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]       base_reg;
    logic [6:0]        total_reg;
    logic [6:0]        reserved_reg;

    logic [LINK_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  free_len_reg, free_len_next;
    logic [CNT_W-1:0]  alloc_reg, alloc_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;
    logic [31:0]       freed_sum_reg, freed_sum_next;
    logic              ready_reg, ready_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [6:0]        remain_reg, remain_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              first_reg, first_next;
    logic [7:0]        owner_reg, owner_next;
    logic [CNT_W-1:0]  freed_reg, freed_next;
    logic [31:0]       paddr_reg, paddr_next;

    logic              done_reg, done_next;
    logic [2:0]        status_reg, status_next;
    logic [31:0]       page_address_reg, page_address_next;
    logic [5:0]        page_index_reg, page_index_next;
    logic [CNT_W-1:0]  pages_freed_reg, pages_freed_next;

    tag_wr_t           tag_wr;
    link_wr_t          link_wr;
    logic [IDX_W-1:0]  tag_raddr;
    logic [IDX_W-1:0]  link_raddr;
    logic [TAG_W-1:0]  tag_rdata;
    logic [LINK_W-1:0] link_rdata;

    logic [CNT_W-1:0]  n_pages;
    logic [CNT_W-1:0]  r_pages;
    logic [CNT_W-1:0]  idx_inc;
    logic [31:0]       addr_diff;
    logic              lookup_hit;
    logic              accept;
    logic              scan_match;
    logic [CNT_W-1:0]  scan_freed;
    logic [31:0]       pop_addr;

    pfa_tag_store u_tag
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tag_wr),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    pfa_link_store u_link
    (
        .clk   (clk),
        .wr    (link_wr),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // pool size and reserved count, clamped
    always_comb
    begin
        if (32'(total_reg) > 32'(NUM_PAGES))
        begin
            n_pages = CNT_W'(NUM_PAGES);
        end
        else
        begin
            n_pages = CNT_W'(total_reg);
        end
        if (32'(reserved_reg) > 32'(n_pages))
        begin
            r_pages = n_pages;
        end
        else
        begin
            r_pages = CNT_W'(reserved_reg);
        end
    end

    assign idx_inc    = idx_reg + CNT_W'(1);
    assign addr_diff  = address - base_reg;
    assign lookup_hit = (addr_diff[PAGE_SHIFT-1:0] == '0)
                     && (32'(addr_diff[31:PAGE_SHIFT]) < 32'(n_pages));
    assign accept     = start && (state_reg == S_IDLE);
    assign scan_match = (tag_rdata == {1'b1, owner_reg});
    assign scan_freed = freed_reg + CNT_W'(scan_match);
    assign pop_addr   = base_reg + (32'(head_reg[IDX_W-1:0]) << PAGE_SHIFT);

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        free_len_next     = free_len_reg;
        alloc_next        = alloc_reg;
        peak_next         = peak_reg;
        freed_sum_next    = freed_sum_reg;
        ready_next        = ready_reg;
        idx_next          = idx_reg;
        remain_next       = remain_reg;
        cnt_next          = cnt_reg;
        first_next        = first_reg;
        owner_next        = owner_reg;
        freed_next        = freed_reg;
        paddr_next        = paddr_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        page_address_next = page_address_reg;
        page_index_next   = page_index_reg;
        pages_freed_next  = pages_freed_reg;
        tag_wr            = '0;
        link_wr           = '0;
        tag_raddr         = '0;
        link_raddr        = head_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next       = ST_OK;
                    page_address_next = '0;
                    page_index_next   = '0;
                    pages_freed_next  = '0;
                    owner_next        = owner_id;
                    idx_next          = '0;
                    freed_next        = '0;
                    first_next        = 1'b1;
                    remain_next       = req_pages;
                    // request size kept for the totals at the end of the pops
                    cnt_next          = CNT_W'(req_pages);
                    if (opcode == OP_INIT)
                    begin
                        if (!ready_reg)
                        begin
                            ready_next     = 1'b1;
                            alloc_next     = r_pages;
                            peak_next      = r_pages;
                            freed_sum_next = '0;
                            free_len_next  = n_pages - r_pages;
                            head_next      = (r_pages < n_pages) ? LINK_W'(r_pages)
                                                                 : NULL_LINK;
                            if (n_pages == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_INIT;
                            end
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    else if (!ready_reg)
                    begin
                        status_next = ST_NOINIT;
                        done_next   = 1'b1;
                    end
                    else if (opcode == OP_ALLOC)
                    begin
                        if (req_pages == '0)
                        begin
                            status_next = ST_ZERO;
                            done_next   = 1'b1;
                        end
                        else if (32'(free_len_reg) < 32'(req_pages))
                        begin
                            status_next = ST_OOM;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    else if (opcode == OP_FREE)
                    begin
                        if (n_pages == '0)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (lookup_hit)
                        begin
                            page_index_next = 6'(addr_diff[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT]);
                        end
                        else
                        begin
                            status_next = ST_NOTFOUND;
                        end
                        done_next = 1'b1;
                    end
                end
            end

            S_INIT:
            begin
                tag_wr.we    = 1'b1;
                tag_wr.addr  = IDX_W'(idx_reg);
                tag_wr.data  = (idx_reg < r_pages) ? {1'b1, KERNEL_OWNER} : '0;
                link_wr.we   = 1'b1;
                link_wr.addr = IDX_W'(idx_reg);
                link_wr.data = ((idx_reg >= r_pages) && (idx_inc < n_pages))
                               ? LINK_W'(idx_inc) : NULL_LINK;
                idx_next     = idx_inc;
                if (idx_inc >= n_pages)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end

            S_POP:
            begin
                // link of the current head arrives this cycle
                tag_wr.we    = 1'b1;
                tag_wr.addr  = head_reg[IDX_W-1:0];
                tag_wr.data  = {1'b1, owner_reg};
                link_wr.we   = 1'b1;
                link_wr.addr = head_reg[IDX_W-1:0];
                link_wr.data = NULL_LINK;
                link_raddr   = link_rdata[IDX_W-1:0];
                head_next    = link_rdata;
                first_next   = 1'b0;
                remain_next  = remain_reg - 7'd1;
                if (first_reg)
                begin
                    paddr_next = pop_addr;
                end
                if (remain_reg == 7'd1)
                begin
                    state_next        = S_IDLE;
                    done_next         = 1'b1;
                    page_address_next = first_reg ? pop_addr : paddr_reg;
                    alloc_next        = alloc_reg + cnt_reg;
                    free_len_next     = free_len_reg - cnt_reg;
                    if ((alloc_reg + cnt_reg) > peak_reg)
                    begin
                        peak_next = alloc_reg + cnt_reg;
                    end
                end
            end

            S_SCAN:
            begin
                tag_raddr = IDX_W'(idx_inc);
                if (scan_match)
                begin
                    tag_wr.we    = 1'b1;
                    tag_wr.addr  = IDX_W'(idx_reg);
                    tag_wr.data  = '0;
                    link_wr.we   = 1'b1;
                    link_wr.addr = IDX_W'(idx_reg);
                    link_wr.data = head_reg;
                    head_next    = LINK_W'(idx_reg);
                end
                freed_next = scan_freed;
                idx_next   = idx_inc;
                if (idx_inc >= n_pages)
                begin
                    state_next       = S_IDLE;
                    done_next        = 1'b1;
                    pages_freed_next = scan_freed;
                    alloc_next       = alloc_reg - scan_freed;
                    free_len_next    = free_len_reg + scan_freed;
                    freed_sum_next   = freed_sum_reg + 32'(scan_freed);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            base_reg         <= '0;
            total_reg        <= 7'd64;
            reserved_reg     <= 7'd1;
            head_reg         <= NULL_LINK;
            free_len_reg     <= '0;
            alloc_reg        <= '0;
            peak_reg         <= '0;
            freed_sum_reg    <= '0;
            ready_reg        <= 1'b0;
            idx_reg          <= '0;
            remain_reg       <= '0;
            cnt_reg          <= '0;
            first_reg        <= 1'b0;
            owner_reg        <= '0;
            freed_reg        <= '0;
            paddr_reg        <= '0;
            done_reg         <= 1'b0;
            status_reg       <= ST_OK;
            page_address_reg <= '0;
            page_index_reg   <= '0;
            pages_freed_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            free_len_reg     <= free_len_next;
            alloc_reg        <= alloc_next;
            peak_reg         <= peak_next;
            freed_sum_reg    <= freed_sum_next;
            ready_reg        <= ready_next;
            idx_reg          <= idx_next;
            remain_reg       <= remain_next;
            cnt_reg          <= cnt_next;
            first_reg        <= first_next;
            owner_reg        <= owner_next;
            freed_reg        <= freed_next;
            paddr_reg        <= paddr_next;
            done_reg         <= done_next;
            status_reg       <= status_next;
            page_address_reg <= page_address_next;
            page_index_reg   <= page_index_next;
            pages_freed_reg  <= pages_freed_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE:     base_reg     <= cfg_data;
                    CFG_TOTAL:    total_reg    <= cfg_data[6:0];
                    CFG_RESERVED: reserved_reg <= cfg_data[6:0];
                    default:      ;
                endcase
            end
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign page_address = page_address_reg;
    assign page_index   = page_index_reg;
    assign pages_freed  = 7'(pages_freed_reg);
    assign pages_in_use = 7'(alloc_reg);
    assign peak_pages   = 7'(peak_reg);
    assign freed_total  = freed_sum_reg;

    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(alloc_reg) <= 32'(NUM_PAGES))
        else $error("allocated count above pool size");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> (head_reg != NULL_LINK))
        else $error("pop from an empty free list");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> ((pages_freed == '0) && (page_address == '0)))
        else $error("failed item carries a payload");

    a_list_len: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NULL_LINK) |-> (free_len_reg == '0))
        else $error("free list length disagrees with head");

endmodule
`default_nettype wire

// ===== rtl/pfa_tag_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_tag_store
// Owner tag memory, one read and one write port, registered read. Entries
// never written read as free with no owner.
// ----------------------------------------------------------------------------
module pfa_tag_store
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire pfa_pkg::tag_wr_t         wr,
    input  wire logic [pfa_pkg::IDX_W-1:0] raddr,
    output logic      [pfa_pkg::TAG_W-1:0] rdata
);
    import pfa_pkg::*;

    logic [TAG_W-1:0]     tag_mem [NUM_PAGES];
    logic [TAG_W-1:0]     rd_reg;
    logic [NUM_PAGES-1:0] vld_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            tag_mem[wr.addr] <= wr.data;
        end
        rd_reg <= tag_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule
`default_nettype wire

// ===== rtl/pfa_link_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_link_store
// Next-free link memory, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module pfa_link_store
(
    input  wire logic                      clk,
    input  wire pfa_pkg::link_wr_t         wr,
    input  wire logic [pfa_pkg::IDX_W-1:0]  raddr,
    output logic      [pfa_pkg::LINK_W-1:0] rdata
);
    import pfa_pkg::*;

    logic [LINK_W-1:0] link_mem [NUM_PAGES];
    logic [LINK_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            link_mem[wr.addr] <= wr.data;
        end
        rd_reg <= link_mem[raddr];
    end

    assign rdata = rd_reg;

endmodule
`default_nettype wire

// ===== test/pfa_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfa_checker
// Watches the command, configuration and result ports of the page frame
// allocator, keeps its own copy of the page table and free list, predicts
// each result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module pfa_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  owner_id,
    input  wire logic [6:0]  req_pages,
    input  wire logic [31:0] address,
    input  wire logic        done,
    input  wire logic [2:0]  status,
    input  wire logic [31:0] page_address,
    input  wire logic [5:0]  page_index,
    input  wire logic [6:0]  pages_freed,
    input  wire logic [6:0]  pages_in_use,
    input  wire logic [6:0]  peak_pages,
    input  wire logic [31:0] freed_total,
    output int               error_count,
    output int               pending
);
    import pfa_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] page_address;
        logic [5:0]  page_index;
        logic [6:0]  pages_freed;
        logic [6:0]  pages_in_use;
        logic [6:0]  peak_pages;
        logic [31:0] freed_total;
    } pfa_result_t;

    logic [31:0]       base_reg;
    logic [6:0]        total_reg;
    logic [6:0]        reserved_reg;
    logic [TAG_W-1:0]  page_tag [NUM_PAGES];
    logic [LINK_W-1:0] page_link [NUM_PAGES];
    logic [LINK_W-1:0] head_ptr;
    int unsigned       alloc_cnt;
    int unsigned       peak_cnt;
    logic [31:0]       freed_sum;
    logic              pool_ready;

    pfa_result_t expected_results [$];

    assign pending = expected_results.size();

    function automatic int unsigned pool_size();
        return (total_reg > NUM_PAGES) ? NUM_PAGES : int'(total_reg);
    endfunction

    function automatic logic [31:0] page_base(int unsigned i);
        return base_reg + (32'(i) << PAGE_SHIFT);
    endfunction

    function automatic pfa_result_t serve_command(logic [1:0] op, logic [7:0] own,
                                                  logic [6:0] cnt, logic [31:0] adr);
        pfa_result_t r;
        int unsigned n;
        int unsigned rsv;
        int unsigned avail;
        int unsigned freed;
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] prev;
        r = '0;
        n = pool_size();
        freed = 0;
        if (op == OP_INIT)
        begin
            if (!pool_ready)
            begin
                rsv = (reserved_reg > n) ? n : int'(reserved_reg);
                head_ptr = NULL_LINK;
                prev = NULL_LINK;
                for (int unsigned i = 0; i < n; i++)
                begin
                    page_link[i] = NULL_LINK;
                    if (i < rsv)
                    begin
                        page_tag[i] = {1'b1, KERNEL_OWNER};
                    end
                    else
                    begin
                        page_tag[i] = '0;
                        if (prev == NULL_LINK) head_ptr = LINK_W'(i);
                        else page_link[prev[IDX_W-1:0]] = LINK_W'(i);
                        prev = LINK_W'(i);
                    end
                end
                alloc_cnt = rsv;
                peak_cnt = rsv;
                freed_sum = '0;
                pool_ready = 1'b1;
            end
        end
        else if (!pool_ready)
        begin
            r.status = ST_NOINIT;
        end
        else if (op == OP_ALLOC)
        begin
            if (cnt == 0)
            begin
                r.status = ST_ZERO;
            end
            else
            begin
                avail = 0;
                p = head_ptr;
                while (p < NUM_PAGES && avail < cnt)
                begin
                    avail++;
                    p = page_link[p[IDX_W-1:0]];
                end
                if (avail < cnt)
                begin
                    r.status = ST_OOM;
                end
                else
                begin
                    for (int unsigned i = 0; i < cnt; i++)
                    begin
                        p = head_ptr;
                        head_ptr = page_link[p[IDX_W-1:0]];
                        page_tag[p[IDX_W-1:0]] = {1'b1, own};
                        page_link[p[IDX_W-1:0]] = NULL_LINK;
                        if (i == 0) r.page_address = page_base(p);
                    end
                    alloc_cnt += cnt;
                    if (alloc_cnt > peak_cnt) peak_cnt = alloc_cnt;
                end
            end
        end
        else if (op == OP_FREE)
        begin
            for (int unsigned i = 0; i < n; i++)
            begin
                if (page_tag[i] == {1'b1, own})
                begin
                    page_tag[i] = '0;
                    page_link[i] = head_ptr;
                    head_ptr = LINK_W'(i);
                    freed++;
                end
            end
            alloc_cnt -= freed;
            freed_sum += 32'(freed);
        end
        else
        begin
            r.status = ST_NOTFOUND;
            for (int unsigned i = 0; i < n; i++)
            begin
                if (page_base(i) == adr)
                begin
                    r.status = ST_OK;
                    r.page_index = 6'(i);
                    break;
                end
            end
        end
        r.pages_freed = 7'(freed);
        r.pages_in_use = 7'(alloc_cnt);
        r.peak_pages = 7'(peak_cnt);
        r.freed_total = freed_sum;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pfa_result_t got;
        pfa_result_t want;
        if (!rst_n)
        begin
            base_reg <= '0;
            total_reg <= 7'd64;
            reserved_reg <= 7'd1;
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                page_tag[i] = '0;
                page_link[i] = NULL_LINK;
            end
            head_ptr = NULL_LINK;
            alloc_cnt = 0;
            peak_cnt = 0;
            freed_sum = '0;
            pool_ready = 1'b0;
            expected_results.delete();
            error_count <= 0;
        end
        else
        begin
            if (done)
            begin
                got = '{status, page_address, page_index, pages_freed,
                        pages_in_use, peak_pages, freed_total};
                if (expected_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("%0t: result with nothing outstanding: %p", $realtime, got);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (error_count < 10)
                            $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE:     base_reg <= cfg_data;
                    CFG_TOTAL:    total_reg <= cfg_data[6:0];
                    CFG_RESERVED: reserved_reg <= cfg_data[6:0];
                    default:      ;
                endcase
            end
            if (start && !busy)
                expected_results.push_back(serve_command(opcode, owner_id, req_pages,
                                                         address));
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the page frame allocator: commands before init, init, then
// directed corner cases and random allocate / free / lookup traffic under
// several idling patterns and register settings. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import pfa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [7:0]  owner_id;
    logic [6:0]  req_pages;
    logic [31:0] address;
    logic        done;
    logic [2:0]  status;
    logic [31:0] page_address;
    logic [5:0]  page_index;
    logic [6:0]  pages_freed;
    logic [6:0]  pages_in_use;
    logic [6:0]  peak_pages;
    logic [31:0] freed_total;
    int          error_count;
    int          pending;
    int          idle_pct;
    int          cycle_count = 0;
    logic [31:0] cur_base;

    page_frame_allocator dut (.*);
    pfa_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] own,
                             input logic [6:0] cnt, input logic [31:0] adr);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        owner_id <= own;
        req_pages <= cnt;
        address <= adr;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        do @(negedge clk); while (pending != 0 || busy);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_BASE) cur_base = val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_owner();
        case ($urandom_range(7))
            0: return KERNEL_OWNER;
            1: return 8'($urandom);
            2: return 8'd0;
            default: return 8'($urandom_range(1, 5));
        endcase
    endfunction

    task automatic random_item();
        logic [6:0]  cnt;
        logic [31:0] adr;
        int unsigned pick;
        pick = $urandom_range(99);
        cnt = ($urandom_range(9) == 0) ? 7'($urandom_range(64))
                                       : 7'($urandom_range(1, 6));
        adr = ($urandom_range(4) == 0) ? $urandom
                                       : cur_base + (32'($urandom_range(70)) << PAGE_SHIFT);
        if (pick < 45)      send_item(OP_ALLOC, pick_owner(), cnt, adr);
        else if (pick < 70) send_item(OP_FREE, pick_owner(), cnt, adr);
        else if (pick < 96) send_item(OP_LOOKUP, pick_owner(), cnt, adr);
        else                send_item(OP_INIT, pick_owner(), cnt, adr);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BASE;
        cfg_data = '0;
        start = 1'b0;
        opcode = OP_ALLOC;
        owner_id = '0;
        req_pages = '0;
        address = '0;
        idle_pct = 0;
        cur_base = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing works before init
        send_item(OP_ALLOC, 8'd1, 7'd1, '0);
        send_item(OP_FREE, KERNEL_OWNER, 7'd0, '0);
        send_item(OP_LOOKUP, 8'd0, 7'd0, '0);
        drain();

        write_reg(CFG_RESERVED, 32'd2);
        write_reg(CFG_TOTAL, 32'd64);
        write_reg(CFG_BASE, 32'hFFFF_8000);
        send_item(OP_INIT, 8'd0, 7'd0, '0);
        send_item(OP_INIT, 8'd9, 7'd5, '0);
        send_item(OP_ALLOC, 8'd1, 7'd0, '0);
        send_item(OP_ALLOC, 8'd1, 7'd64, '0);
        send_item(OP_ALLOC, 8'd255, 7'd62, '0);
        send_item(OP_ALLOC, 8'd1, 7'd1, '0);
        send_item(OP_LOOKUP, 8'd0, 7'd0, 32'hFFFF_8000);
        send_item(OP_LOOKUP, 8'd0, 7'd0, 32'hFFFF_8000 + (32'd63 << PAGE_SHIFT));
        send_item(OP_LOOKUP, 8'd0, 7'd0, 32'hFFFF_8000 + (32'd64 << PAGE_SHIFT));
        send_item(OP_LOOKUP, 8'd0, 7'd0, 32'hFFFF_8001);
        send_item(OP_LOOKUP, 8'd0, 7'd0, 32'hFFFF_FFFF);
        send_item(OP_FREE, 8'd7, 7'd0, '0);
        // kernel free also hands back the reserved pages
        send_item(OP_FREE, KERNEL_OWNER, 7'd0, '0);
        send_item(OP_ALLOC, 8'd0, 7'd64, '0);
        send_item(OP_FREE, 8'd0, 7'd0, '0);
        send_item(OP_ALLOC, 8'hAA, 7'd3, 32'hAAAA_5555);
        send_item(OP_ALLOC, 8'h55, 7'd2, 32'h5555_AAAA);
        send_item(OP_FREE, 8'hAA, 7'h7F, '0);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                1: write_reg(CFG_BASE, $urandom);
                2: write_reg(CFG_TOTAL, 32'd1);
                3: write_reg(CFG_TOTAL, 32'h7F);
                4: write_reg(CFG_RESERVED, 32'd64);
                5: write_reg(CFG_TOTAL, 32'd0);
                default: write_reg(CFG_RESERVED, 32'd0);
            endcase
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 87 : 36);
            for (int k = 0; k < 225; k++)
            begin
                random_item();
                if (ph == 1 && k == 100) drain();
            end
            if (ph == 2)
            begin
                drain();
                write_reg(CFG_TOTAL, 32'd64);
                write_reg(CFG_BASE, 32'd0);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (error_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
